// ===== sv/aavr_pkg.sv =====
`default_nettype none

package aavr_pkg;

  // Configuration register indexes.
  localparam logic [1:0] REG_AX = 2'd0;
  localparam logic [1:0] REG_AY = 2'd1;
  localparam logic [1:0] REG_AZ = 2'd2;

  localparam logic [31:0] TWO_PI_Q28  = 32'd1686629713;
  localparam logic [31:0] PI_Q28      = 32'd843314857;
  localparam logic [31:0] HALF_PI_Q28 = 32'd421657428;
  localparam logic [31:0] CORDIC_GAIN = 32'd652032874;
  localparam logic [31:0] ONE_Q30     = 32'd1073741824;
  localparam int          CORDIC_STEPS = 31;

  typedef struct packed {
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
    logic               inverse;
  } in_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
  } out_t;

  // Coefficients derived from the rotation vector, plus the status of the unit
  // that derives them.
  typedef struct packed {
    logic               busy;
    logic               zero;
    logic signed [31:0] kx;
    logic signed [31:0] ky;
    logic signed [31:0] kz;
    logic signed [31:0] sn;
    logic signed [31:0] cs;
  } coef_t;

  function automatic logic [31:0] atan_q30(input logic [4:0] i);
    logic [31:0] t;
    case (i)
      5'd0:  t = 32'h3243F6A8;
      5'd1:  t = 32'h1DAC6705;
      5'd2:  t = 32'h0FADBAFC;
      5'd3:  t = 32'h07F56EA6;
      5'd4:  t = 32'h03FEAB76;
      5'd5:  t = 32'h01FFD55B;
      5'd6:  t = 32'h00FFFAAA;
      5'd7:  t = 32'h007FFF55;
      5'd8:  t = 32'h003FFFEA;
      5'd9:  t = 32'h001FFFFD;
      5'd10: t = 32'h000FFFFF;
      5'd11: t = 32'h0007FFFF;
      5'd12: t = 32'h0003FFFF;
      5'd13: t = 32'h0001FFFF;
      5'd14: t = 32'h0000FFFF;
      5'd15: t = 32'h00007FFF;
      5'd16: t = 32'h00003FFF;
      5'd17: t = 32'h00001FFF;
      5'd18: t = 32'h00000FFF;
      5'd19: t = 32'h000007FF;
      5'd20: t = 32'h000003FF;
      5'd21: t = 32'h000001FF;
      5'd22: t = 32'h000000FF;
      5'd23: t = 32'h0000007F;
      5'd24: t = 32'h0000003F;
      5'd25: t = 32'h0000001F;
      5'd26: t = 32'h0000000F;
      5'd27: t = 32'h00000008;
      5'd28: t = 32'h00000004;
      5'd29: t = 32'h00000002;
      5'd30: t = 32'h00000001;
      default: t = 32'h00000000;
    endcase
    return t;
  endfunction

  // Fixed-point product in Q.30, truncated toward zero.
  function automatic logic signed [39:0] mulq(input logic signed [36:0] a,
                                              input logic signed [32:0] b);
    logic [36:0] ma;
    logic [32:0] mb;
    logic [69:0] p;
    logic [39:0] q;
    ma = a[36] ? 37'(-a) : 37'(a);
    mb = b[32] ? 33'(-b) : 33'(b);
    p  = 70'(ma) * 70'(mb);
    q  = p[69:30];
    return (a[36] ^ b[32]) ? -$signed(q) : $signed(q);
  endfunction

endpackage

`default_nettype wire

// ===== sv/aavr_coef.sv =====
`default_nettype none

module aavr_coef (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_valid,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [31:0]   cfg_data,
  output aavr_pkg::coef_t    coef
);

  typedef enum logic [3:0] {
    IDLE, SQ, SQRT, DLD, DIV, RED, FOLD, CORD, FIN
  } state_t;

  state_t             state;
  logic [31:0]        a [3];
  logic [5:0]         cnt;
  logic [1:0]         ci;
  logic [63:0]        acc;
  logic [63:0]        res;
  logic [63:0]        bitm;
  logic [31:0]        theta;
  logic [61:0]        dv;
  logic [31:0]        rem;
  logic [31:0]        quo;
  logic [31:0]        r;
  logic               neg;
  logic signed [33:0] x;
  logic signed [33:0] y;
  logic signed [35:0] z;
  logic signed [31:0] kreg [3];
  logic signed [31:0] sn;
  logic signed [31:0] cs;
  logic               zero;

  logic [31:0]        amag;
  logic [63:0]        sq;
  logic [63:0]        acc_next;
  logic [63:0]        trial;
  logic               sq_ge;
  logic [63:0]        res_next;
  logic [32:0]        rem_sh;
  logic               div_ge;
  logic [31:0]        quo_next;
  logic signed [33:0] f0;
  logic signed [33:0] f1;
  logic               fneg;
  logic signed [33:0] dx;
  logic signed [33:0] dy;
  logic signed [35:0] at;
  logic signed [33:0] xn;
  logic signed [33:0] yn;
  logic signed [33:0] one_s;

  always_comb begin
    amag     = a[ci][31] ? 32'(-a[ci]) : a[ci];
    sq       = 64'(amag) * 64'(amag);
    acc_next = acc + sq;
    trial    = res + bitm;
    sq_ge    = acc >= trial;
    res_next = sq_ge ? ((res >> 1) + bitm) : (res >> 1);
    rem_sh   = {rem, dv[61]};
    div_ge   = rem_sh >= {1'b0, theta};
    quo_next = {quo[30:0], div_ge};
    f0       = $signed({2'b00, r});
    if (f0 >= $signed({2'b00, aavr_pkg::PI_Q28})) begin
      f0 = f0 - $signed({2'b00, aavr_pkg::TWO_PI_Q28});
    end
    fneg = 1'b0;
    f1   = f0;
    if (f0 > $signed({2'b00, aavr_pkg::HALF_PI_Q28})) begin
      f1   = f0 - $signed({2'b00, aavr_pkg::PI_Q28});
      fneg = 1'b1;
    end else if (f0 < -$signed({2'b00, aavr_pkg::HALF_PI_Q28})) begin
      f1   = f0 + $signed({2'b00, aavr_pkg::PI_Q28});
      fneg = 1'b1;
    end
    dx    = y >>> cnt[4:0];
    dy    = x >>> cnt[4:0];
    at    = $signed({4'b0000, aavr_pkg::atan_q30(cnt[4:0])});
    xn    = neg ? -x : x;
    yn    = neg ? -y : y;
    one_s = $signed({2'b00, aavr_pkg::ONE_Q30});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      a[0]  <= '0;
      a[1]  <= '0;
      a[2]  <= '0;
      zero  <= 1'b1;
      cnt   <= '0;
      ci    <= '0;
    end else if (cfg_valid && (cfg_index == aavr_pkg::REG_AX ||
                               cfg_index == aavr_pkg::REG_AY ||
                               cfg_index == aavr_pkg::REG_AZ)) begin
      unique case (cfg_index)
        aavr_pkg::REG_AX: a[0] <= cfg_data;
        aavr_pkg::REG_AY: a[1] <= cfg_data;
        default:          a[2] <= cfg_data;
      endcase
      state <= SQ;
      ci    <= '0;
      acc   <= '0;
    end else begin
      unique case (state)
        IDLE: begin
        end
        SQ: begin
          acc <= acc_next;
          if (ci == 2'd2) begin
            ci <= '0;
            if (acc_next == '0) begin
              zero  <= 1'b1;
              state <= IDLE;
            end else begin
              zero  <= 1'b0;
              res   <= '0;
              bitm  <= 64'd1 << 62;
              cnt   <= '0;
              state <= SQRT;
            end
          end else begin
            ci <= ci + 2'd1;
          end
        end
        SQRT: begin
          if (sq_ge) begin
            acc <= acc - trial;
          end
          res  <= res_next;
          bitm <= bitm >> 2;
          cnt  <= cnt + 6'd1;
          if (cnt == 6'd31) begin
            theta <= res_next[31:0];
            state <= DLD;
          end
        end
        DLD: begin
          dv    <= {amag, 30'd0};
          rem   <= '0;
          quo   <= '0;
          cnt   <= '0;
          state <= DIV;
        end
        DIV: begin
          rem <= div_ge ? 32'(rem_sh - {1'b0, theta}) : rem_sh[31:0];
          quo <= quo_next;
          dv  <= dv << 1;
          cnt <= cnt + 6'd1;
          if (cnt == 6'd61) begin
            kreg[ci] <= a[ci][31] ? -$signed(quo_next) : $signed(quo_next);
            if (ci == 2'd2) begin
              r     <= theta;
              state <= RED;
            end else begin
              ci    <= ci + 2'd1;
              state <= DLD;
            end
          end
        end
        RED: begin
          if (r >= aavr_pkg::TWO_PI_Q28) begin
            r <= r - aavr_pkg::TWO_PI_Q28;
          end else begin
            state <= FOLD;
          end
        end
        FOLD: begin
          z     <= {f1, 2'b00};
          x     <= $signed({2'b00, aavr_pkg::CORDIC_GAIN});
          y     <= '0;
          neg   <= fneg;
          cnt   <= '0;
          state <= CORD;
        end
        CORD: begin
          if (z >= 0) begin
            x <= x - dx;
            y <= y + dy;
            z <= z - at;
          end else begin
            x <= x + dx;
            y <= y - dy;
            z <= z + at;
          end
          cnt <= cnt + 6'd1;
          if (cnt == 6'(aavr_pkg::CORDIC_STEPS - 1)) begin
            state <= FIN;
          end
        end
        FIN: begin
          cs    <= (xn > one_s) ? 32'(one_s) : (xn < -one_s) ? 32'(-one_s) : 32'(xn);
          sn    <= (yn > one_s) ? 32'(one_s) : (yn < -one_s) ? 32'(-one_s) : 32'(yn);
          state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

  always_comb begin
    coef.busy = state != IDLE;
    coef.zero = zero;
    coef.kx   = kreg[0];
    coef.ky   = kreg[1];
    coef.kz   = kreg[2];
    coef.sn   = sn;
    coef.cs   = cs;
  end

endmodule

`default_nettype wire

// ===== sv/aavr_datapath.sv =====
`default_nettype none

module aavr_datapath (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            adv,
  input  wire logic            in_take,
  input  wire aavr_pkg::in_t   in_data,
  input  wire aavr_pkg::coef_t coef,
  output logic                 out_valid,
  output aavr_pkg::out_t       out_data
);

  logic v1, v2, v3, v4;

  // Stage 1: products of the axis with the vector, and of the vector with cos.
  logic signed [32:0] p_xx, p_yy, p_zz, p_yz, p_zy, p_zx, p_xz, p_xy, p_yx;
  logic signed [32:0] vc1 [3];
  logic signed [31:0] vv1 [3];
  logic               inv1;
  // Stage 2: dot product and cross product.
  logic signed [34:0] d2;
  logic signed [33:0] c2 [3];
  logic signed [32:0] vc2 [3];
  logic signed [31:0] vv2 [3];
  logic               inv2;
  // Stage 3: dot product times one minus cos, cross product times sin.
  logic signed [35:0] g3;
  logic signed [34:0] cs3 [3];
  logic signed [32:0] vc3 [3];
  logic signed [31:0] vv3 [3];
  // Stage 4: axis times the scaled dot product.
  logic signed [36:0] kg4 [3];
  logic signed [34:0] cs4 [3];
  logic signed [32:0] vc4 [3];
  logic signed [31:0] vv4 [3];

  logic signed [32:0] omc;
  logic signed [32:0] sn_eff;
  logic signed [41:0] sum [3];
  logic signed [31:0] res [3];
  logic signed [31:0] kk  [3];

  always_comb begin
    kk[0]  = coef.kx;
    kk[1]  = coef.ky;
    kk[2]  = coef.kz;
    omc    = $signed({1'b0, aavr_pkg::ONE_Q30}) - 33'(coef.cs);
    sn_eff = inv2 ? -33'(coef.sn) : 33'(coef.sn);
    for (int i = 0; i < 3; i++) begin
      sum[i] = 42'(kg4[i]) + 42'(cs4[i]) + 42'(vc4[i]);
      if (sum[i] > 42'sd2147483647) begin
        res[i] = 32'sh7FFFFFFF;
      end else if (sum[i] < -42'sd2147483648) begin
        res[i] = 32'sh80000000;
      end else begin
        res[i] = sum[i][31:0];
      end
      if (coef.zero) begin
        res[i] = vv4[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= in_take;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_xx   <= 33'(aavr_pkg::mulq(37'(coef.kx), 33'(in_data.vec_x)));
      p_yy   <= 33'(aavr_pkg::mulq(37'(coef.ky), 33'(in_data.vec_y)));
      p_zz   <= 33'(aavr_pkg::mulq(37'(coef.kz), 33'(in_data.vec_z)));
      p_yz   <= 33'(aavr_pkg::mulq(37'(coef.ky), 33'(in_data.vec_z)));
      p_zy   <= 33'(aavr_pkg::mulq(37'(coef.kz), 33'(in_data.vec_y)));
      p_zx   <= 33'(aavr_pkg::mulq(37'(coef.kz), 33'(in_data.vec_x)));
      p_xz   <= 33'(aavr_pkg::mulq(37'(coef.kx), 33'(in_data.vec_z)));
      p_xy   <= 33'(aavr_pkg::mulq(37'(coef.kx), 33'(in_data.vec_y)));
      p_yx   <= 33'(aavr_pkg::mulq(37'(coef.ky), 33'(in_data.vec_x)));
      vc1[0] <= 33'(aavr_pkg::mulq(37'(in_data.vec_x), 33'(coef.cs)));
      vc1[1] <= 33'(aavr_pkg::mulq(37'(in_data.vec_y), 33'(coef.cs)));
      vc1[2] <= 33'(aavr_pkg::mulq(37'(in_data.vec_z), 33'(coef.cs)));
      vv1[0] <= in_data.vec_x;
      vv1[1] <= in_data.vec_y;
      vv1[2] <= in_data.vec_z;
      inv1   <= in_data.inverse;

      d2    <= 35'(p_xx) + 35'(p_yy) + 35'(p_zz);
      c2[0] <= 34'(p_yz) - 34'(p_zy);
      c2[1] <= 34'(p_zx) - 34'(p_xz);
      c2[2] <= 34'(p_xy) - 34'(p_yx);
      vc2   <= vc1;
      vv2   <= vv1;
      inv2  <= inv1;

      g3  <= 36'(aavr_pkg::mulq(37'(d2), omc));
      for (int i = 0; i < 3; i++) begin
        cs3[i] <= 35'(aavr_pkg::mulq(37'(c2[i]), sn_eff));
        kg4[i] <= 37'(aavr_pkg::mulq(37'(g3), 33'(kk[i])));
      end
      vc3 <= vc2;
      vv3 <= vv2;

      cs4 <= cs3;
      vc4 <= vc3;
      vv4 <= vv3;

      out_data.out_x <= res[0];
      out_data.out_y <= res[1];
      out_data.out_z <= res[2];
    end
  end

endmodule

`default_nettype wire

// ===== sv/axis_angle_vector_rotation.sv =====
// Axis-angle vector rotation by Rodrigues' formula in fixed point.
//
// Channels: the in word carries a Q16.16 vector and an inverse flag, the out
// word carries the rotated vector, saturated to 32 bits. Both use valid and
// ready. The cfg channel writes the rotation vector (Q4.28), one component
// per word; a write to an index beyond the three components is ignored.
//
// Each word appears on out after five register stages of multipliers and
// adders (the first loaded at acceptance), one 37 by 33 bit product per path
// at most; one word may be accepted in every cycle while out is not stalled
// and the coefficients are not being recomputed.
//
// After a write to a component the coefficient unit works out the angle, the
// unit axis, sine and cosine with a square root, three bit-serial divisions
// and a CORDIC loop, taking longer the further the angle must be reduced (a
// zero rotation vector skips all but the squaring); in_ready is held low
// meanwhile. Reset clears the rotation vector to zero, which passes vectors
// through, and leaves the block ready at once.
//
// When the receiver stalls, the whole pipeline holds and in_ready falls, so
// no word is lost or repeated.
`default_nettype none

module axis_angle_vector_rotation (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire aavr_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output aavr_pkg::out_t      out_data,
  input  wire logic           cfg_valid,
  output logic                cfg_ready,
  input  wire logic [1:0]     cfg_index,
  input  wire logic [31:0]    cfg_data
);

  aavr_pkg::coef_t coef;
  logic            adv;
  logic            in_take;

  // The pipeline moves whenever the output register is free or being emptied.
  assign adv       = !out_valid || out_ready;
  assign in_ready  = adv && !coef.busy;
  assign in_take   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  aavr_coef u_coef (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coef      (coef)
  );

  aavr_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_take   (in_take),
    .in_data   (in_data),
    .coef      (coef),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // No word may enter while the coefficients are being recomputed.
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !coef.busy)
    else $error("word accepted while coefficients are busy");

  // A write to a component must start a recompute.
  a_cfg_starts: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready && (cfg_index == aavr_pkg::REG_AX ||
      cfg_index == aavr_pkg::REG_AY || cfg_index == aavr_pkg::REG_AZ)
    |=> coef.busy)
    else $error("configuration write did not start a recompute");

  // A stalled result stays in the output register.
  a_out_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result lost");

endmodule

`default_nettype wire

// ===== dv/tb_axis_angle_vector_rotation.sv =====
`default_nettype none

module tb_axis_angle_vector_rotation;

  // Clock, reset and the block's ports.
  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  aavr_pkg::in_t    in_data = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  aavr_pkg::out_t   out_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [1:0]       cfg_index = aavr_pkg::REG_AX;
  logic [31:0]      cfg_data = '0;

  always #1 clk = ~clk;

  axis_angle_vector_rotation i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // The predictor keeps its own copy of the rotation vector, updated whenever
  // the testbench writes a component.
  logic signed [31:0] rot_vec [3];

  // Rotated vectors still owed by the block, oldest first.
  aavr_pkg::out_t rotated_q[$];

  int  n_errors   = 0;
  int  n_words    = 0;
  int  n_rotated  = 0;
  int  n_settings = 0;
  bit  hold_off   = 1'b0;

  localparam longint UNIT_Q30 = 64'sd1073741824;
  localparam longint FULL_TURN = 64'sd1686629713;
  localparam longint HALF_TURN = 64'sd843314857;
  localparam longint QUARTER_TURN = 64'sd421657428;

  // Truncating Q.30 product; operands are small enough that 128 bits suffice.
  function automatic longint fx_mul(input longint a, input longint b);
    logic [127:0] p;
    longint       ma, mb;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    p  = 128'(ma) * 128'(mb);
    p  = p >> 30;
    return ((a < 0) != (b < 0)) ? -longint'(p[63:0]) : longint'(p[63:0]);
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] n);
    logic [63:0] res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n   = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [31:0] saturate(input longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  // Angle to sine and cosine: fold the angle into the quarter circle around
  // zero, then run the CORDIC loop in Q2.30 and clamp to unit magnitude.
  task automatic angle_sin_cos(input logic [63:0] theta, output longint sn,
                               output longint cs);
    longint r, x, y, z, dx, dy;
    bit     flip;
    r    = longint'(theta % 64'(FULL_TURN));
    flip = 1'b0;
    x    = longint'(aavr_pkg::CORDIC_GAIN);
    y    = 0;
    if (r >= HALF_TURN) r -= FULL_TURN;
    if (r > QUARTER_TURN) begin
      r -= HALF_TURN;
      flip = 1'b1;
    end else if (r < -QUARTER_TURN) begin
      r += HALF_TURN;
      flip = 1'b1;
    end
    z = r * 4;
    for (int i = 0; i < aavr_pkg::CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= longint'(aavr_pkg::atan_q30(5'(i)));
      end else begin
        x += dx;
        y -= dy;
        z += longint'(aavr_pkg::atan_q30(5'(i)));
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    cs = (x > UNIT_Q30) ? UNIT_Q30 : ((x < -UNIT_Q30) ? -UNIT_Q30 : x);
    sn = (y > UNIT_Q30) ? UNIT_Q30 : ((y < -UNIT_Q30) ? -UNIT_Q30 : y);
  endtask

  task automatic rotate_vector(input aavr_pkg::in_t w, output aavr_pkg::out_t res);
    longint      v[3], a[3], k[3], cr[3];
    longint      sn, cs, d, g, q;
    logic [63:0] sum_sq, theta, ma;
    v[0] = w.vec_x;
    v[1] = w.vec_y;
    v[2] = w.vec_z;
    sum_sq = 0;
    for (int i = 0; i < 3; i++) begin
      a[i]   = rot_vec[i];
      ma     = (a[i] < 0) ? 64'(-a[i]) : 64'(a[i]);
      sum_sq += ma * ma;
    end
    // A zero rotation vector passes the word straight through.
    if (sum_sq == 0) begin
      res.out_x = w.vec_x;
      res.out_y = w.vec_y;
      res.out_z = w.vec_z;
      return;
    end
    theta = int_sqrt(sum_sq);
    for (int i = 0; i < 3; i++) begin
      ma   = (a[i] < 0) ? 64'(-a[i]) : 64'(a[i]);
      q    = longint'((ma << 30) / theta);
      k[i] = (a[i] < 0) ? -q : q;
    end
    angle_sin_cos(theta, sn, cs);
    if (w.inverse) sn = -sn;
    d     = fx_mul(k[0], v[0]) + fx_mul(k[1], v[1]) + fx_mul(k[2], v[2]);
    cr[0] = fx_mul(k[1], v[2]) - fx_mul(k[2], v[1]);
    cr[1] = fx_mul(k[2], v[0]) - fx_mul(k[0], v[2]);
    cr[2] = fx_mul(k[0], v[1]) - fx_mul(k[1], v[0]);
    g     = fx_mul(d, UNIT_Q30 - cs);
    res.out_x = saturate(fx_mul(v[0], cs) + fx_mul(cr[0], sn) + fx_mul(k[0], g));
    res.out_y = saturate(fx_mul(v[1], cs) + fx_mul(cr[1], sn) + fx_mul(k[1], g));
    res.out_z = saturate(fx_mul(v[2], cs) + fx_mul(cr[2], sn) + fx_mul(k[2], g));
  endtask

  // Writes one component, only while nothing is in flight. The coefficient
  // unit then holds in_ready low until it has finished, so the next word
  // waits for it.
  task automatic write_component(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx <= aavr_pkg::REG_AZ) rot_vec[idx] = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_rotation(input logic [31:0] ax, input logic [31:0] ay,
                              input logic [31:0] az);
    write_component(aavr_pkg::REG_AX, ax);
    write_component(aavr_pkg::REG_AY, ay);
    write_component(aavr_pkg::REG_AZ, az);
    // An index beyond the three components must leave them alone.
    write_component(2'd3, $urandom);
    n_settings++;
  endtask

  // Offers one word after an optional random gap, holds it until it is taken. The
  // expectation is worked out at acceptance, with the rotation then in force.
  // Valid stays high on return so that words can follow back to back; a gap
  // or drain() lowers it.
  task automatic send_word(input aavr_pkg::in_t w, input bit with_gap);
    aavr_pkg::out_t exp_res;
    int             gap;
    gap = with_gap ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    rotate_vector(w, exp_res);
    rotated_q.push_back(exp_res);
    n_words++;
    @(negedge clk);
  endtask

  // Directed vectors with a known answer, or the predictor where the answer
  // is not obvious. Used under the zero rotation, so results are the input.
  typedef struct {
    aavr_pkg::in_t  word;
    bit             known;
    aavr_pkg::out_t answer;
  } row_t;

  row_t directed[$];

  function automatic row_t mk_row(input logic [31:0] x, input logic [31:0] y,
                                  input logic [31:0] z, input logic inv,
                                  input bit known);
    row_t r;
    r.word   = '{vec_x: x, vec_y: y, vec_z: z, inverse: inv};
    r.known  = known;
    r.answer = '{out_x: x, out_y: y, out_z: z};
    return r;
  endfunction

  function automatic logic [31:0] rand_field();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'(int'($urandom_range(0, 131072)) - 65536);
      3: return 32'(int'($urandom_range(0, 1 << 24)) - (1 << 23));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_angle();
    case ($urandom_range(0, 6))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'(int'($urandom_range(0, 8)) - 4);
      3: return 32'h0;
      4: return 32'(int'($urandom_range(0, 1 << 29)) - (1 << 28));
      default: return $urandom;
    endcase
  endfunction

  // Stops offering words and waits until every expected word has arrived.
  task automatic drain();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (rotated_q.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    // Five pipeline stages; a little margin beyond that.
    repeat (10) @(posedge clk);
  endtask

  // Receiver: random stalls per word, and one long hold-off on request.
  initial begin
    int stall;
    @(negedge clk);
    while (1) begin
      if (hold_off) begin
        out_ready <= 1'b0;
        repeat (300) @(negedge clk);
        hold_off = 1'b0;
      end
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // Checker: each accepted word against the oldest expectation.
  always @(posedge clk) begin
    aavr_pkg::out_t exp_res;
    if (!rst && out_valid && out_ready) begin
      if (rotated_q.size() == 0) begin
        $error("rotated word with no expectation waiting: %h", out_data);
        n_errors++;
      end else begin
        exp_res = rotated_q.pop_front();
        n_rotated++;
        if (out_data.out_x !== exp_res.out_x) begin
          $error("out_x expected %0d got %0d", exp_res.out_x, out_data.out_x);
          n_errors++;
        end
        if (out_data.out_y !== exp_res.out_y) begin
          $error("out_y expected %0d got %0d", exp_res.out_y, out_data.out_y);
          n_errors++;
        end
        if (out_data.out_z !== exp_res.out_z) begin
          $error("out_z expected %0d got %0d", exp_res.out_z, out_data.out_z);
          n_errors++;
        end
      end
    end
  end

  // Main sequence.
  initial begin
    aavr_pkg::out_t exp_res;
    aavr_pkg::in_t  w;
    bit             burst;
    for (int i = 0; i < 3; i++) rot_vec[i] = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part: extremes of every field and both inverse settings under
    // the reset rotation, which passes words through untouched. The words
    // follow one another with no gap, starting right after reset.
    directed.push_back(mk_row(32'h0, 32'h0, 32'h0, 1'b0, 1'b1));
    directed.push_back(mk_row(32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 1'b1, 1'b1));
    directed.push_back(mk_row(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1));
    directed.push_back(mk_row(32'hFFFF_FFFF, 32'h0001_0000, 32'h7FFF_FFFF, 1'b1, 1'b1));
    directed.push_back(mk_row(32'h0001_0000, 32'hFFFF_0000, 32'h8000_0000, 1'b0, 1'b1));
    foreach (directed[i]) begin
      if (directed[i].known) begin
        rotated_q.push_back(directed[i].answer);
      end else begin
        rotate_vector(directed[i].word, exp_res);
        rotated_q.push_back(exp_res);
      end
      in_valid <= 1'b1;
      in_data  <= directed[i].word;
      do @(posedge clk); while (!in_ready);
      n_words++;
      @(negedge clk);
    end
    drain();

    // Quarter turn about z, a tiny rotation vector whose floored length
    // overstretches the axis, and the most negative and most positive extremes;
    // checked against the predictor.
    set_rotation(32'd0, 32'd0, QUARTER_TURN[31:0]);
    send_word('{vec_x: 32'h0001_0000, vec_y: 32'h0, vec_z: 32'h0, inverse: 1'b0}, 1'b0);
    send_word('{vec_x: 32'h0001_0000, vec_y: 32'h0, vec_z: 32'h0, inverse: 1'b1}, 1'b0);
    send_word('{vec_x: 32'h7FFF_FFFF, vec_y: 32'h7FFF_FFFF, vec_z: 32'h8000_0000,
                inverse: 1'b0}, 1'b0);
    drain();
    set_rotation(32'd1, 32'd1, 32'd1);
    send_word('{vec_x: 32'h7FFF_FFFF, vec_y: 32'h8000_0000, vec_z: 32'h1234_5678,
                inverse: 1'b1}, 1'b0);
    send_word('{vec_x: 32'h0001_0000, vec_y: 32'h0002_0000, vec_z: 32'h0003_0000,
                inverse: 1'b0}, 1'b0);
    drain();
    set_rotation(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_word('{vec_x: 32'h8000_0000, vec_y: 32'h7FFF_FFFF, vec_z: 32'h8000_0000,
                inverse: 1'b1}, 1'b0);
    send_word('{vec_x: 32'h0001_0000, vec_y: 32'hFFFF_0000, vec_z: 32'h0, inverse: 1'b0},
              1'b0);
    drain();
    set_rotation(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_word('{vec_x: 32'h7FFF_FFFF, vec_y: 32'h8000_0000, vec_z: 32'h7FFF_FFFF,
                inverse: 1'b0}, 1'b0);
    drain();

    // Random part: phases under random rotation vectors. Some phases run with
    // no idling on the sender, and one asks the receiver for a long hold-off
    // while words keep coming, so the pipeline fills and in_ready drops.
    for (int ph = 0; ph < 30; ph++) begin
      set_rotation(rand_angle(), rand_angle(), rand_angle());
      burst = (ph % 4 == 1);
      if (ph == 3) hold_off = 1'b1;
      for (int j = 0; j < 61; j++) begin
        w.vec_x   = rand_field();
        w.vec_y   = rand_field();
        w.vec_z   = rand_field();
        w.inverse = $urandom_range(0, 1);
        send_word(w, !burst);
      end
      drain();
    end
    // Back to the zero rotation to finish.
    set_rotation(32'd0, 32'd0, 32'd0);
    for (int j = 0; j < 10; j++) begin
      w = '{vec_x: $urandom, vec_y: $urandom, vec_z: $urandom, inverse: 1'(j)};
      send_word(w, 1'b1);
    end
    drain();

    if (rotated_q.size() != 0) begin
      $error("%0d rotated words never arrived", rotated_q.size());
      n_errors++;
    end
    $display("Sent %0d vectors under %0d rotation settings, %0d results checked.",
             n_words, n_settings, n_rotated);
    if (n_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #4000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

`default_nettype wire
